FILE: rtl/ptds_pkg.sv
// Shared constants, command and result codes, and beat types for the task scheduler.
package ptds_pkg;

  // Table size and tick counter limit.
  localparam int MAX_TASKS = 8;
  localparam logic [31:0] TICK_MAX = 32'd2147483647;

  // Field widths of the input and result beats.
  localparam int CMD_W    = 2;
  localparam int PERIOD_W = 15;
  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 3;
  localparam int TICK_W   = 31;

  // Derived widths for the slot table and the dispatch walk.
  localparam int IDX_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W       = $clog2(MAX_TASKS + 1);
  localparam int MAX_RESULTS = 8;
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam logic [PERIOD_W-1:0] ELAPSED_CAP = 15'h7FFF;

  // Queue depths between the front, the engine and the result port.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CREATE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

  // Result kind codes.
  localparam logic [KIND_W-1:0] KIND_TICK_DONE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TASK_DUE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NONE_DUE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CREATE_OK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CREATE_REF = 3'd4;

  // One command beat as held in the command queue.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [PERIOD_W-1:0] period;
  } cmd_beat_t;

  // One result beat as held in the result queue.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              lock;
    logic [TICK_W-1:0] tick_now;
    logic              last;
  } result_t;

endpackage

FILE: rtl/periodic_task_due_scheduler_core.sv
// Top level of the periodic task scheduler: front queue, engine and result queue.
//
// Usage: input beats (cmd, period) are written like a queue: a beat is taken on a
// rising edge with push high and full low. Tick and create beats each give one
// result; a dispatch gives one result per due slot (at most eight), or a single
// none-due result, and the final result of every item carries last. Unused
// command code 3 is dropped at the front and gives no result.
// Results are read like a queue: while empty is low the oldest result sits on
// kind, slot, lock, tick_now and last, and pop with empty low takes it.
// A tick or create beat is registered in the command queue, then in the result queue.
// Throughput: ticks and creates run at one per cycle while the result queue
// has room; a dispatch holds the engine through its walk and final steps, and
// the walk visits one table slot per cycle while the result queue has room.
// A two-entry command queue lets the front keep taking beats during a walk.
// When the receiver stalls, the four-entry result queue fills, the engine holds
// its place, and full rises once the command queue is also filled.
// Reset (rst, synchronous) empties both queues, clears the tick counter, the slot
// count and the creation lock; only creates and dispatch walks write the table.
module periodic_task_due_scheduler_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [ptds_pkg::CMD_W-1:0]    cmd,
  input  logic [ptds_pkg::PERIOD_W-1:0] period,
  output logic                          empty,
  input  logic                          pop,
  output logic [ptds_pkg::KIND_W-1:0]   kind,
  output logic [ptds_pkg::SLOT_W-1:0]   slot,
  output logic                          lock,
  output logic [ptds_pkg::TICK_W-1:0]   tick_now,
  output logic                          last
);
  import ptds_pkg::*;

  logic      q_valid;
  logic      q_take;
  cmd_beat_t q_beat;
  logic      r_push;
  logic      r_full;
  result_t   r_beat;
  result_t   head;

  // Front end with the command queue.
  ptds_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .cmd     (cmd),
    .period  (period),
    .q_valid (q_valid),
    .q_take  (q_take),
    .q_beat  (q_beat)
  );

  // Command engine with the slot table.
  ptds_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_take  (q_take),
    .q_beat  (q_beat),
    .r_push  (r_push),
    .r_full  (r_full),
    .r_beat  (r_beat)
  );

  // Result queue toward the reader.
  ptds_result_queue u_result_queue (
    .clk    (clk),
    .rst    (rst),
    .r_push (r_push),
    .r_full (r_full),
    .r_beat (r_beat),
    .empty  (empty),
    .pop    (pop),
    .head   (head)
  );

  // Result fields come straight from the queue head.
  assign kind     = head.kind;
  assign slot     = head.slot;
  assign lock     = head.lock;
  assign tick_now = head.tick_now;
  assign last     = head.last;

endmodule

FILE: rtl/ptds_front.sv
// Front end: accepts input beats, drops unused commands and queues the rest.
module ptds_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [ptds_pkg::CMD_W-1:0]    cmd,
  input  logic [ptds_pkg::PERIOD_W-1:0] period,
  output logic                       q_valid,
  input  logic                       q_take,
  output ptds_pkg::cmd_beat_t        q_beat
);
  import ptds_pkg::*;

  cmd_beat_t             entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] fill;
  logic                  keep;
  logic                  taken;

  // A beat is stored only when its command does something.
  assign full    = (fill == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign keep    = push && !full && (cmd != CMD_UNUSED);
  assign taken   = q_take && q_valid;
  assign q_valid = (fill != '0);
  assign q_beat  = entries[rd_ptr];

  // Storage is written at the write pointer and needs no reset.
  always_ff @(posedge clk) begin
    if (keep) begin
      entries[wr_ptr] <= '{cmd: cmd, period: period};
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (keep) begin
        wr_ptr <= (wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (taken) begin
        rd_ptr <= (rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (keep && !taken) begin
        fill <= fill + 1'b1;
      end else if (!keep && taken) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ptds_engine.sv
// Back end: holds the slot table and the tick counter and carries out each command.
module ptds_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_take,
  input  ptds_pkg::cmd_beat_t q_beat,
  output logic                r_push,
  input  logic                r_full,
  output ptds_pkg::result_t   r_beat
);
  import ptds_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [PERIOD_W-1:0] slot_period   [MAX_TASKS];
  logic [TICK_W-1:0]   slot_last_run [MAX_TASKS];

  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  slot_count, slot_count_next;
  logic              create_lock, create_lock_next;
  logic [TICK_W-1:0] tick_counter, tick_counter_next;
  logic [IDX_W-1:0]  walk_idx, walk_idx_next;
  logic              pend_valid, pend_valid_next;
  logic [SLOT_W-1:0] pend_slot, pend_slot_next;
  logic [RCNT_W-1:0] reported, reported_next;

  logic              new_slot_we;
  logic              last_run_we;
  logic [31:0]       tick_inc;
  logic [TICK_W-1:0] tick_wrapped;
  logic [31:0]       now_w;
  logic [31:0]       lr_w;
  logic [31:0]       diff;
  logic [PERIOD_W-1:0] elapsed;
  logic              due;
  logic              walk_end;
  logic              go;

  // Next tick value, wrapping to zero on reaching the limit.
  assign tick_inc     = {1'b0, tick_counter} + 32'd1;
  assign tick_wrapped = (tick_inc >= TICK_MAX) ? '0 : tick_inc[TICK_W-1:0];

  // Elapsed ticks of the slot under the walk, saturated and compared with its period.
  assign now_w   = {1'b0, tick_counter};
  assign lr_w    = {1'b0, slot_last_run[walk_idx]};
  assign diff    = (now_w >= lr_w) ? (now_w - lr_w) : ((TICK_MAX - lr_w) + now_w);
  assign elapsed = (diff > 32'(ELAPSED_CAP)) ? ELAPSED_CAP : diff[PERIOD_W-1:0];
  assign due     = (elapsed >= slot_period[walk_idx]);

  assign walk_end = ((CNT_W'(walk_idx) + CNT_W'(1)) == slot_count);
  assign go       = !r_full;

  // Command decode, walk sequencing and result formation.
  always_comb begin
    state_next        = state;
    slot_count_next   = slot_count;
    create_lock_next  = create_lock;
    tick_counter_next = tick_counter;
    walk_idx_next     = walk_idx;
    pend_valid_next   = pend_valid;
    pend_slot_next    = pend_slot;
    reported_next     = reported;
    new_slot_we       = 1'b0;
    last_run_we       = 1'b0;
    q_take            = 1'b0;
    r_push            = 1'b0;
    r_beat            = '{kind: KIND_NONE_DUE, slot: '0, lock: create_lock,
                          tick_now: tick_counter, last: 1'b1};
    unique case (state)
      ST_IDLE: begin
        if (q_valid && go) begin
          q_take = 1'b1;
          unique case (q_beat.cmd)
            CMD_TICK: begin
              tick_counter_next = tick_wrapped;
              create_lock_next  = 1'b1;
              r_push            = 1'b1;
              r_beat = '{kind: KIND_TICK_DONE, slot: '0, lock: 1'b1,
                         tick_now: tick_wrapped, last: 1'b1};
            end
            CMD_CREATE: begin
              r_push = 1'b1;
              if (!create_lock && (slot_count < CNT_W'(MAX_TASKS))) begin
                new_slot_we     = 1'b1;
                slot_count_next = slot_count + 1'b1;
                r_beat = '{kind: KIND_CREATE_OK, slot: SLOT_W'(slot_count),
                           lock: create_lock, tick_now: tick_counter, last: 1'b1};
              end else begin
                create_lock_next = 1'b1;
                r_beat = '{kind: KIND_CREATE_REF, slot: '0, lock: 1'b1,
                           tick_now: tick_counter, last: 1'b1};
              end
            end
            CMD_DISPATCH: begin
              if (slot_count == '0) begin
                r_push = 1'b1;
              end else begin
                state_next      = ST_WALK;
                walk_idx_next   = '0;
                pend_valid_next = 1'b0;
                reported_next   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        // One slot per cycle while go is high; a due slot releases the one held before it.
        if (go) begin
          if (due) begin
            last_run_we = 1'b1;
            if (reported < RCNT_W'(MAX_RESULTS)) begin
              if (pend_valid) begin
                r_push = 1'b1;
                r_beat = '{kind: KIND_TASK_DUE, slot: pend_slot, lock: create_lock,
                           tick_now: tick_counter, last: 1'b0};
              end
              pend_valid_next = 1'b1;
              pend_slot_next  = SLOT_W'(walk_idx);
              reported_next   = reported + 1'b1;
            end
          end
          if (walk_end) begin
            state_next = ST_FINAL;
          end else begin
            walk_idx_next = walk_idx + 1'b1;
          end
        end
      end
      ST_FINAL: begin
        // The held slot closes the dispatch, or the none-due beat does.
        if (go) begin
          r_push     = 1'b1;
          state_next = ST_IDLE;
          if (pend_valid) begin
            r_beat = '{kind: KIND_TASK_DUE, slot: pend_slot, lock: create_lock,
                       tick_now: tick_counter, last: 1'b1};
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Slot table writes: a new slot on create, the current tick on a due slot.
  always_ff @(posedge clk) begin
    if (new_slot_we) begin
      slot_period[slot_count[IDX_W-1:0]]   <= q_beat.period;
      slot_last_run[slot_count[IDX_W-1:0]] <= '0;
    end
    if (last_run_we) begin
      slot_last_run[walk_idx] <= tick_counter;
    end
  end

  // Control state and walk bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot_count   <= '0;
      create_lock  <= 1'b0;
      tick_counter <= '0;
      walk_idx     <= '0;
      pend_valid   <= 1'b0;
      pend_slot    <= '0;
      reported     <= '0;
    end else begin
      state        <= state_next;
      slot_count   <= slot_count_next;
      create_lock  <= create_lock_next;
      tick_counter <= tick_counter_next;
      walk_idx     <= walk_idx_next;
      pend_valid   <= pend_valid_next;
      pend_slot    <= pend_slot_next;
      reported     <= reported_next;
    end
  end

endmodule

FILE: rtl/ptds_result_queue.sv
// Result queue: buffers result beats between the engine and the result port.
module ptds_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              r_push,
  output logic              r_full,
  input  ptds_pkg::result_t r_beat,
  output logic              empty,
  input  logic              pop,
  output ptds_pkg::result_t head
);
  import ptds_pkg::*;

  result_t               entries [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr;
  logic [RESQ_PTR_W-1:0] rd_ptr;
  logic [RESQ_CNT_W-1:0] fill;
  logic                  wr;
  logic                  rd;

  assign r_full = (fill == RESQ_CNT_W'(RESQ_DEPTH));
  assign empty  = (fill == '0);
  assign wr     = r_push && !r_full;
  assign rd     = pop && !empty;
  assign head   = entries[rd_ptr];

  // Result storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= r_beat;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        fill <= fill + 1'b1;
      end else if (!wr && rd) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
